// ===== src/tpfpu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the twin phase-field point update unit.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package tpfpu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DIMS   = 3;
  localparam int unsigned COEF_W = 20;
  localparam int unsigned ROW_W  = 60;
  localparam int unsigned DT_W   = 31;
  localparam int unsigned WIDE_W = 40;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned DEN_W  = 33;
  localparam int unsigned NUM_W  = 48;
  localparam int unsigned QUOT_W = 17;

  // Added to the gradient length, in raw Q16.16 steps.
  localparam logic [DEN_W-1:0] NORM_EPSILON = 33'd1;

  localparam logic signed [WIDE_W-1:0] Q_ONE  = 40'sd65536;
  localparam logic signed [WIDE_W-1:0] Q_HALF = 40'sd32768;
  localparam logic signed [WIDE_W-1:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -40'sd2147483648;

  localparam logic [4:0] FRAC_Q = 5'd16;
  localparam logic [4:0] FRAC_C = 5'd12;

  localparam logic [2:0] REG_KAPPA0    = 3'd0;
  localparam logic [2:0] REG_KAPPA1    = 3'd1;
  localparam logic [2:0] REG_KAPPA2    = 3'd2;
  localparam logic [2:0] REG_MOBILITY0 = 3'd3;
  localparam logic [2:0] REG_MOBILITY1 = 3'd4;
  localparam logic [2:0] REG_MOBILITY2 = 3'd5;
  localparam logic [2:0] REG_WELL      = 3'd6;
  localparam logic [2:0] REG_TIME_STEP = 3'd7;

  // A saturating result together with its clip flag.
  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } qres_t;

  // Per-point data that rides alongside the normal computation.
  typedef struct packed {
    logic [31:0]           n;
    logic [31:0]           s;
    logic [31:0]           f;
    logic [31:0]           p2;
    logic [DIMS-1:0][31:0] kg;
    logic [DIMS-1:0]       gneg;
    logic                  clip;
  } side_t;

  // Exact product, rounded right shift with ties away from zero, clipped to 32 bits.
  function automatic qres_t mulq(input logic signed [31:0] a, input logic signed [31:0] b,
                                 input logic [4:0] frac);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] lim;
    logic [63:0] prod;
    logic [64:0] rnd;
    logic [64:0] q;
    qres_t       r;
    neg   = a[31] ^ b[31];
    ma    = a[31] ? (~a + 32'd1) : a;
    mb    = b[31] ? (~b + 32'd1) : b;
    prod  = 64'(ma) * 64'(mb);
    rnd   = {1'b0, prod} + (65'd1 << (frac - 5'd1));
    q     = rnd >> frac;
    lim   = 32'h7fff_ffff + {31'd0, neg};
    r.clip = (q > {33'd0, lim});
    if (r.clip) begin
      q = {33'd0, lim};
    end
    r.val = neg ? (~q[31:0] + 32'd1) : q[31:0];
    return r;
  endfunction

  // Clip a wide signed value to the 32-bit range.
  function automatic qres_t satw(input logic signed [WIDE_W-1:0] v);
    qres_t r;
    r.clip = (v > SAT_HI) || (v < SAT_LO);
    if (v > SAT_HI) begin
      r.val = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r.val = SAT_LO[31:0];
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Coefficient j of a packed tensor row, sign extended from Q8.12.
  function automatic logic signed [31:0] coef(input logic [ROW_W-1:0] row, input int unsigned j);
    logic signed [COEF_W-1:0] c;
    c = signed'(row[COEF_W*j +: COEF_W]);
    return 32'(c);
  endfunction

endpackage

`default_nettype wire

// ===== src/tpfpu_norm.sv =====
// Unit normal magnitudes: pipelined square root of the squared gradient length, then a
// pipelined restoring divide per axis. Depends on tpfpu_pkg.
`default_nettype none

module tpfpu_norm (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               en_i,
  input  logic                                               valid_i,
  input  logic [tpfpu_pkg::SQ_W-1:0]                         sqsum_i,
  input  logic [tpfpu_pkg::DIMS-1:0][31:0]                   gmag_i,
  input  tpfpu_pkg::side_t                                   side_i,
  output logic                                               valid_o,
  output logic [tpfpu_pkg::DIMS-1:0][tpfpu_pkg::QUOT_W-1:0] quot_o,
  output tpfpu_pkg::side_t                                   side_o
);
  import tpfpu_pkg::*;

  // Square root stages, one result bit per stage.
  logic                  sq_v_q    [ROOT_W];
  logic [33:0]           sq_rem_q  [ROOT_W];
  logic [ROOT_W-1:0]     sq_root_q [ROOT_W];
  logic [SQ_W-1:0]       sq_x_q    [ROOT_W];
  logic [DIMS-1:0][31:0] sq_gm_q   [ROOT_W];
  side_t                 sq_sd_q   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic                  v_in;
    logic [33:0]           rem_in;
    logic [ROOT_W-1:0]     root_in;
    logic [SQ_W-1:0]       x_in;
    logic [DIMS-1:0][31:0] gm_in;
    side_t                 sd_in;
    logic [35:0]           remx;
    logic [35:0]           trial;
    logic                  ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = sqsum_i;
      assign gm_in   = gmag_i;
      assign sd_in   = side_i;
    end else begin : g_next
      assign v_in    = sq_v_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign x_in    = sq_x_q[k-1];
      assign gm_in   = sq_gm_q[k-1];
      assign sd_in   = sq_sd_q[k-1];
    end

    always_comb begin
      remx  = {rem_in, x_in[SQ_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      ge    = (remx >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en_i) begin
        sq_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem_q[k]  <= ge ? 34'(remx - trial) : remx[33:0];
        sq_root_q[k] <= {root_in[ROOT_W-2:0], ge};
        sq_x_q[k]    <= {x_in[SQ_W-3:0], 2'b00};
        sq_gm_q[k]   <= gm_in;
        sq_sd_q[k]   <= sd_in;
      end
    end
  end

  // Denominator stage, then numerator stage that also seeds the dividers.
  logic                  dn_v_q;
  logic [DEN_W-1:0]      dn_den_q;
  logic [DIMS-1:0][31:0] dn_gm_q;
  side_t                 dn_sd_q;

  logic                          nm_v_q;
  logic [DEN_W-1:0]              nm_den_q;
  logic [DIMS-1:0][DEN_W-1:0]    nm_r_q;
  logic [DIMS-1:0][QUOT_W-1:0]   nm_nb_q;
  side_t                         nm_sd_q;
  logic [DIMS-1:0][NUM_W-1:0]    num_c;

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      num_c[i] = {dn_gm_q[i], 16'd0} + NUM_W'(dn_den_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_v_q <= 1'b0;
      nm_v_q <= 1'b0;
    end else if (en_i) begin
      dn_v_q <= sq_v_q[ROOT_W-1];
      nm_v_q <= dn_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn_den_q <= {1'b0, sq_root_q[ROOT_W-1]} + NORM_EPSILON;
      dn_gm_q  <= sq_gm_q[ROOT_W-1];
      dn_sd_q  <= sq_sd_q[ROOT_W-1];
      nm_den_q <= dn_den_q;
      nm_sd_q  <= dn_sd_q;
      for (int i = 0; i < DIMS; i++) begin
        nm_r_q[i]  <= DEN_W'(num_c[i][NUM_W-1:QUOT_W]);
        nm_nb_q[i] <= num_c[i][QUOT_W-1:0];
      end
    end
  end

  // Restoring divide, one quotient bit per stage in each lane.
  logic                        dv_v_q   [QUOT_W];
  logic [DEN_W-1:0]            dv_den_q [QUOT_W];
  logic [DIMS-1:0][DEN_W-1:0]  dv_r_q   [QUOT_W];
  logic [DIMS-1:0][QUOT_W-1:0] dv_nb_q  [QUOT_W];
  logic [DIMS-1:0][QUOT_W-1:0] dv_q_q   [QUOT_W];
  side_t                       dv_sd_q  [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    logic                        v_in;
    logic [DEN_W-1:0]            den_in;
    logic [DIMS-1:0][DEN_W-1:0]  r_in;
    logic [DIMS-1:0][QUOT_W-1:0] nb_in;
    logic [DIMS-1:0][QUOT_W-1:0] q_in;
    side_t                       sd_in;
    logic [DIMS-1:0][DEN_W:0]    r2;
    logic [DIMS-1:0]             ge;

    if (k == 0) begin : g_first
      assign v_in   = nm_v_q;
      assign den_in = nm_den_q;
      assign r_in   = nm_r_q;
      assign nb_in  = nm_nb_q;
      assign q_in   = '0;
      assign sd_in  = nm_sd_q;
    end else begin : g_next
      assign v_in   = dv_v_q[k-1];
      assign den_in = dv_den_q[k-1];
      assign r_in   = dv_r_q[k-1];
      assign nb_in  = dv_nb_q[k-1];
      assign q_in   = dv_q_q[k-1];
      assign sd_in  = dv_sd_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < DIMS; i++) begin
        r2[i] = {r_in[i], nb_in[i][QUOT_W-1]};
        ge[i] = (r2[i] >= {1'b0, den_in});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_den_q[k] <= den_in;
        dv_sd_q[k]  <= sd_in;
        for (int i = 0; i < DIMS; i++) begin
          dv_r_q[k][i]  <= ge[i] ? DEN_W'(r2[i] - {1'b0, den_in}) : r2[i][DEN_W-1:0];
          dv_nb_q[k][i] <= {nb_in[i][QUOT_W-2:0], 1'b0};
          dv_q_q[k][i]  <= {q_in[i][QUOT_W-2:0], ge[i]};
        end
      end
    end
  end

  assign valid_o = dv_v_q[QUOT_W-1];
  assign quot_o  = dv_q_q[QUOT_W-1];
  assign side_o  = dv_sd_q[QUOT_W-1];

endmodule

`default_nettype wire

// ===== src/twin_phase_field_point_update_unit.sv =====
// Top level of the twin phase-field point update: register file, front and back pipeline.
// Depends on tpfpu_pkg and tpfpu_norm.
`default_nettype none

// Channel   | Direction | Handshake              | Word
// ----------+-----------+------------------------+----------------------------------------
// input     | in        | in_valid_i/in_ready_o  | order value, gradient xyz, strain force
// output    | out       | out_valid_o/out_ready_i| next and rate terms, saturation flag
// config    | in        | APB psel/penable       | 64-bit data, register i at byte 8*i
//
// One word enters per cycle unless the output stalls. The depth comes mainly from the
// normal computation: a 32-stage square root and a 17-stage divide, one bit per stage.
// Reset clears every valid bit and all configuration registers; data registers hold garbage.
// All stages share one enable, so a full output register with out_ready_i low freezes the
// whole pipeline and holds in_ready_o low; nothing is lost or repeated.

module twin_phase_field_point_update_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [5:0]                           paddr,
  input  logic [63:0]                          pwdata,
  output logic [63:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [tpfpu_pkg::DATA_W-1:0] order_value_i,
  input  logic signed [tpfpu_pkg::DATA_W-1:0] grad_x_i,
  input  logic signed [tpfpu_pkg::DATA_W-1:0] grad_y_i,
  input  logic signed [tpfpu_pkg::DATA_W-1:0] grad_z_i,
  input  logic signed [tpfpu_pkg::DATA_W-1:0] strain_force_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tpfpu_pkg::DATA_W-1:0] next_value_o,
  output logic signed [tpfpu_pkg::DATA_W-1:0] next_flux_x_o,
  output logic signed [tpfpu_pkg::DATA_W-1:0] next_flux_y_o,
  output logic signed [tpfpu_pkg::DATA_W-1:0] next_flux_z_o,
  output logic signed [tpfpu_pkg::DATA_W-1:0] rate_value_o,
  output logic signed [tpfpu_pkg::DATA_W-1:0] rate_flux_x_o,
  output logic signed [tpfpu_pkg::DATA_W-1:0] rate_flux_y_o,
  output logic signed [tpfpu_pkg::DATA_W-1:0] rate_flux_z_o,
  output logic                                 saturated_o
);
  import tpfpu_pkg::*;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; there are no wait
  // states, and every 3-bit register index names a real register.
  // ---------------------------------------------------------------------------------------
  logic [ROW_W-1:0]   kappa_q [DIMS];
  logic [ROW_W-1:0]   mob_q   [DIMS];
  logic signed [31:0] well_q;
  logic [DT_W-1:0]    dt_q;
  logic               cfg_we;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIMS; i++) begin
        kappa_q[i] <= '0;
        mob_q[i]   <= '0;
      end
      well_q <= '0;
      dt_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KAPPA0:    kappa_q[0] <= pwdata[ROW_W-1:0];
        REG_KAPPA1:    kappa_q[1] <= pwdata[ROW_W-1:0];
        REG_KAPPA2:    kappa_q[2] <= pwdata[ROW_W-1:0];
        REG_MOBILITY0: mob_q[0]   <= pwdata[ROW_W-1:0];
        REG_MOBILITY1: mob_q[1]   <= pwdata[ROW_W-1:0];
        REG_MOBILITY2: mob_q[2]   <= pwdata[ROW_W-1:0];
        REG_WELL:      well_q     <= signed'(pwdata[31:0]);
        REG_TIME_STEP: dt_q       <= pwdata[DT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KAPPA0:    prdata = 64'(kappa_q[0]);
      REG_KAPPA1:    prdata = 64'(kappa_q[1]);
      REG_KAPPA2:    prdata = 64'(kappa_q[2]);
      REG_MOBILITY0: prdata = 64'(mob_q[0]);
      REG_MOBILITY1: prdata = 64'(mob_q[1]);
      REG_MOBILITY2: prdata = 64'(mob_q[2]);
      REG_WELL:      prdata = {32'd0, well_q};
      REG_TIME_STEP: prdata = 64'(dt_q);
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Global pipeline enable. The output register is the last stage; the pipeline moves
  // whenever that register is empty or being drained.
  // ---------------------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------------------------------
  // Stage 1: capture the word and form n-1, n-1/2 and 2n-1.
  // ---------------------------------------------------------------------------------------
  logic               v1_q;
  logic signed [31:0] n1_q, s1_q, a1_q, b1_q, t1_q;
  logic signed [31:0] g1_q [DIMS];
  logic               c1_q;
  qres_t              a_c, b_c, t_c;
  logic signed [31:0] gin [DIMS];

  always_comb begin
    gin[0] = grad_x_i;
    gin[1] = grad_y_i;
    gin[2] = grad_z_i;
    a_c = satw(40'(order_value_i) - Q_ONE);
    b_c = satw(40'(order_value_i) - Q_HALF);
    t_c = satw((40'(order_value_i) <<< 1) - Q_ONE);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= order_value_i;
      s1_q <= strain_force_i;
      a1_q <= a_c.val;
      b1_q <= b_c.val;
      t1_q <= t_c.val;
      c1_q <= a_c.clip | b_c.clip | t_c.clip;
      for (int i = 0; i < DIMS; i++) begin
        g1_q[i] <= gin[i];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: n*(n-1), (2n-1)^2, the nine gradient tensor products, squared gradients.
  // ---------------------------------------------------------------------------------------
  logic               v2_q;
  logic signed [31:0] n2_q, s2_q, b2_q, p1_q, tt_q;
  logic signed [31:0] kt_q [DIMS][DIMS];
  logic [SQ_W-1:0]    sqr_q [DIMS];
  logic [31:0]        gm2_q [DIMS];
  logic [DIMS-1:0]    gneg2_q;
  logic               c2_q;
  qres_t              p1_c, tt_c;
  qres_t              kt_c [DIMS][DIMS];
  logic [31:0]        gm_c [DIMS];
  logic               c2_c;

  always_comb begin
    p1_c = mulq(n1_q, a1_q, FRAC_Q);
    tt_c = mulq(t1_q, t1_q, FRAC_Q);
    c2_c = c1_q | p1_c.clip | tt_c.clip;
    for (int i = 0; i < DIMS; i++) begin
      gm_c[i] = g1_q[i][31] ? (~g1_q[i] + 32'd1) : g1_q[i];
      for (int j = 0; j < DIMS; j++) begin
        kt_c[i][j] = mulq(coef(kappa_q[i], j), g1_q[j], FRAC_C);
        c2_c       = c2_c | kt_c[i][j].clip;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q <= n1_q;
      s2_q <= s1_q;
      b2_q <= b1_q;
      p1_q <= p1_c.val;
      tt_q <= tt_c.val;
      c2_q <= c2_c;
      for (int i = 0; i < DIMS; i++) begin
        sqr_q[i]   <= 64'(gm_c[i]) * 64'(gm_c[i]);
        gm2_q[i]   <= gm_c[i];
        gneg2_q[i] <= g1_q[i][31];
        for (int j = 0; j < DIMS; j++) begin
          kt_q[i][j] <= kt_c[i][j].val;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: cubic term, filter factor 1-(2n-1)^2, K*grad n and the squared length.
  // ---------------------------------------------------------------------------------------
  logic                  v3_q;
  side_t                 sd3_q;
  logic [SQ_W-1:0]       sqsum3_q;
  logic [DIMS-1:0][31:0] gm3_q;
  qres_t                 p2_c, f_c;
  qres_t                 kg_c [DIMS];
  side_t                 sd3_c;

  always_comb begin
    p2_c = mulq(p1_q, b2_q, FRAC_Q);
    f_c  = satw(Q_ONE - 40'(tt_q));
    sd3_c.n    = n2_q;
    sd3_c.s    = s2_q;
    sd3_c.f    = f_c.val;
    sd3_c.p2   = p2_c.val;
    sd3_c.gneg = gneg2_q;
    sd3_c.clip = c2_q | p2_c.clip | f_c.clip;
    for (int i = 0; i < DIMS; i++) begin
      kg_c[i]     = satw(40'(kt_q[i][0]) + 40'(kt_q[i][1]) + 40'(kt_q[i][2]));
      sd3_c.kg[i] = kg_c[i].val;
      sd3_c.clip  = sd3_c.clip | kg_c[i].clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd3_q    <= sd3_c;
      sqsum3_q <= sqr_q[0] + sqr_q[1] + sqr_q[2];
      for (int i = 0; i < DIMS; i++) begin
        gm3_q[i] <= gm2_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Normal magnitudes: |g_i| * 2^16 / (|g| + eps), rounded, over 51 stages.
  // ---------------------------------------------------------------------------------------
  logic                        nr_v;
  logic [DIMS-1:0][QUOT_W-1:0] nr_quot;
  side_t                       nr_sd;

  tpfpu_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .sqsum_i (sqsum3_q),
    .gmag_i  (gm3_q),
    .side_i  (sd3_q),
    .valid_o (nr_v),
    .quot_o  (nr_quot),
    .side_o  (nr_sd)
  );

  // ---------------------------------------------------------------------------------------
  // Back end 1: signed normal, outer products v_i*v_j, double-well term, filtered force.
  // The normal points against the gradient, so a negative gradient gives a positive v_i.
  // ---------------------------------------------------------------------------------------
  logic               e1_v_q;
  logic signed [31:0] e1_nvp_q [DIMS][DIMS];
  logic signed [31:0] e1_mu_q, e1_filt_q, e1_n_q;
  logic signed [31:0] e1_kg_q [DIMS];
  logic               e1_c_q;
  logic signed [31:0] nv_c [DIMS];
  qres_t              nvp_c [DIMS][DIMS];
  qres_t              p4_c, mu_c, filt_c;
  logic               e1_c;

  always_comb begin
    p4_c   = satw(40'(signed'(nr_sd.p2)) * 40'sd4);
    mu_c   = mulq(well_q, p4_c.val, FRAC_Q);
    filt_c = mulq(signed'(nr_sd.f), signed'(nr_sd.s), FRAC_Q);
    e1_c   = nr_sd.clip | p4_c.clip | mu_c.clip | filt_c.clip;
    for (int i = 0; i < DIMS; i++) begin
      nv_c[i] = nr_sd.gneg[i] ? signed'(32'(nr_quot[i])) : -signed'(32'(nr_quot[i]));
    end
    for (int i = 0; i < DIMS; i++) begin
      for (int j = 0; j < DIMS; j++) begin
        nvp_c[i][j] = mulq(nv_c[i], nv_c[j], FRAC_Q);
        e1_c        = e1_c | nvp_c[i][j].clip;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_mu_q   <= mu_c.val;
      e1_filt_q <= filt_c.val;
      e1_n_q    <= signed'(nr_sd.n);
      e1_c_q    <= e1_c;
      for (int i = 0; i < DIMS; i++) begin
        e1_kg_q[i] <= signed'(nr_sd.kg[i]);
        for (int j = 0; j < DIMS; j++) begin
          e1_nvp_q[i][j] <= nvp_c[i][j].val;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Back end 2: mobility products M_ij*v_i*v_j and the driving difference mu - filtered.
  // ---------------------------------------------------------------------------------------
  logic               e2_v_q;
  logic signed [31:0] e2_mt_q [DIMS][DIMS];
  logic signed [31:0] e2_d_q, e2_n_q;
  logic signed [31:0] e2_kg_q [DIMS];
  logic               e2_c_q;
  qres_t              mt_c [DIMS][DIMS];
  qres_t              d_c;
  logic               e2_c;

  always_comb begin
    d_c  = satw(40'(e1_mu_q) - 40'(e1_filt_q));
    e2_c = e1_c_q | d_c.clip;
    for (int i = 0; i < DIMS; i++) begin
      for (int j = 0; j < DIMS; j++) begin
        mt_c[i][j] = mulq(coef(mob_q[i], j), e1_nvp_q[i][j], FRAC_C);
        e2_c       = e2_c | mt_c[i][j].clip;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_d_q <= d_c.val;
      e2_n_q <= e1_n_q;
      e2_c_q <= e2_c;
      for (int i = 0; i < DIMS; i++) begin
        e2_kg_q[i] <= e1_kg_q[i];
        for (int j = 0; j < DIMS; j++) begin
          e2_mt_q[i][j] <= mt_c[i][j].val;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Back end 3: directional mobility L as the sum of the nine terms.
  // ---------------------------------------------------------------------------------------
  logic               e3_v_q;
  logic signed [31:0] e3_l_q, e3_d_q, e3_n_q;
  logic signed [31:0] e3_kg_q [DIMS];
  logic               e3_c_q;
  logic signed [WIDE_W-1:0] lsum_c;
  qres_t              l_c;

  always_comb begin
    lsum_c = '0;
    for (int i = 0; i < DIMS; i++) begin
      for (int j = 0; j < DIMS; j++) begin
        lsum_c = lsum_c + 40'(e2_mt_q[i][j]);
      end
    end
    l_c = satw(lsum_c);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_l_q <= l_c.val;
      e3_d_q <= e2_d_q;
      e3_n_q <= e2_n_q;
      e3_c_q <= e2_c_q | l_c.clip;
      for (int i = 0; i < DIMS; i++) begin
        e3_kg_q[i] <= e2_kg_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Back end 4: L*d and L*(K grad n).
  // ---------------------------------------------------------------------------------------
  logic               e4_v_q;
  logic signed [31:0] e4_ld_q, e4_n_q;
  logic signed [31:0] e4_lk_q [DIMS];
  logic               e4_c_q;
  qres_t              ld_c;
  qres_t              lk_c [DIMS];
  logic               e4_c;

  always_comb begin
    ld_c = mulq(e3_l_q, e3_d_q, FRAC_Q);
    e4_c = e3_c_q | ld_c.clip;
    for (int i = 0; i < DIMS; i++) begin
      lk_c[i] = mulq(e3_l_q, e3_kg_q[i], FRAC_Q);
      e4_c    = e4_c | lk_c[i].clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e4_ld_q <= ld_c.val;
      e4_n_q  <= e3_n_q;
      e4_c_q  <= e4_c;
      for (int i = 0; i < DIMS; i++) begin
        e4_lk_q[i] <= lk_c[i].val;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Back end 5: scale by the time step and negate for the rate terms.
  // ---------------------------------------------------------------------------------------
  logic               e5_v_q;
  logic signed [31:0] e5_dl_q, e5_rv_q, e5_n_q;
  logic signed [31:0] e5_dk_q [DIMS];
  logic signed [31:0] e5_rf_q [DIMS];
  logic               e5_c_q;
  logic signed [31:0] dt_s;
  qres_t              dl_c, rv_c;
  qres_t              dk_c [DIMS];
  qres_t              rf_c [DIMS];
  logic               e5_c;

  always_comb begin
    dt_s = signed'({1'b0, dt_q});
    dl_c = mulq(dt_s, e4_ld_q, FRAC_Q);
    rv_c = satw(-40'(e4_ld_q));
    e5_c = e4_c_q | dl_c.clip | rv_c.clip;
    for (int i = 0; i < DIMS; i++) begin
      dk_c[i] = mulq(dt_s, e4_lk_q[i], FRAC_Q);
      rf_c[i] = satw(-40'(e4_lk_q[i]));
      e5_c    = e5_c | dk_c[i].clip | rf_c[i].clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e5_dl_q <= dl_c.val;
      e5_rv_q <= rv_c.val;
      e5_n_q  <= e4_n_q;
      e5_c_q  <= e5_c;
      for (int i = 0; i < DIMS; i++) begin
        e5_dk_q[i] <= dk_c[i].val;
        e5_rf_q[i] <= rf_c[i].val;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register: explicit update terms n - dt*L*d and -dt*L*(K grad n).
  // ---------------------------------------------------------------------------------------
  qres_t              nx_c;
  qres_t              nf_c [DIMS];
  logic               out_c;
  logic signed [31:0] nx_q, rv_q;
  logic signed [31:0] nf_q [DIMS];
  logic signed [31:0] rf_q [DIMS];
  logic               sat_q;

  always_comb begin
    nx_c  = satw(40'(e5_n_q) - 40'(e5_dl_q));
    out_c = e5_c_q | nx_c.clip;
    for (int i = 0; i < DIMS; i++) begin
      nf_c[i] = satw(-40'(e5_dk_q[i]));
      out_c   = out_c | nf_c[i].clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q  <= nx_c.val;
      rv_q  <= e5_rv_q;
      sat_q <= out_c;
      for (int i = 0; i < DIMS; i++) begin
        nf_q[i] <= nf_c[i].val;
        rf_q[i] <= e5_rf_q[i];
      end
    end
  end

  // Valid bits of every stage outside the normal unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      e1_v_q      <= 1'b0;
      e2_v_q      <= 1'b0;
      e3_v_q      <= 1'b0;
      e4_v_q      <= 1'b0;
      e5_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      e1_v_q      <= nr_v;
      e2_v_q      <= e1_v_q;
      e3_v_q      <= e2_v_q;
      e4_v_q      <= e3_v_q;
      e5_v_q      <= e4_v_q;
      out_valid_q <= e5_v_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_value_o  = nx_q;
  assign next_flux_x_o = nf_q[0];
  assign next_flux_y_o = nf_q[1];
  assign next_flux_z_o = nf_q[2];
  assign rate_value_o  = rv_q;
  assign rate_flux_x_o = rf_q[0];
  assign rate_flux_y_o = rf_q[1];
  assign rate_flux_z_o = rf_q[2];
  assign saturated_o   = sat_q;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------

  // A stall freezes every valid bit of the back end and front end.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable({v1_q, v2_q, v3_q, e1_v_q, e2_v_q, e3_v_q, e4_v_q, e5_v_q}))
    else $error("pipeline valid bits moved during a stall");

  // The rate terms are saturated negations of 32-bit values, so they never reach the most negative code.
  a_rate_not_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rate_value_o != 32'sh8000_0000) && (rate_flux_x_o != 32'sh8000_0000)
                    && (rate_flux_y_o != 32'sh8000_0000) && (rate_flux_z_o != 32'sh8000_0000))
    else $error("rate term holds the most negative value");

  // A new result appears only when the pipeline advanced in the previous cycle.
  a_result_needs_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared without a pipeline advance");

endmodule

`default_nettype wire

// ===== verif/tb_twin_phase_field_point_update_unit.sv =====
// Self-checking testbench for twin_phase_field_point_update_unit: directed table, then random
// points under several register settings, each checked against a Q16.16 point-update predictor.
// Depends on tpfpu_pkg and the unit's RTL only.
`default_nettype none

module tb_twin_phase_field_point_update_unit;
  import tpfpu_pkg::*;

  // One result word as the unit emits it.
  typedef struct packed {
    logic signed [31:0] next_value;
    logic signed [31:0] next_flux_x;
    logic signed [31:0] next_flux_y;
    logic signed [31:0] next_flux_z;
    logic signed [31:0] rate_value;
    logic signed [31:0] rate_flux_x;
    logic signed [31:0] rate_flux_y;
    logic signed [31:0] rate_flux_z;
    logic               saturated;
  } point_result_t;

  // A directed stimulus row. Where the result is obvious it is typed in and used as is.
  typedef struct {
    logic signed [31:0] n;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic signed [31:0] s;
    bit                 known;
    point_result_t      res;
  } point_row_t;

  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sd65536;
  localparam int unsigned DRAIN_CYCLES = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic signed [31:0] order_value_i = '0;
  logic signed [31:0] grad_x_i = '0;
  logic signed [31:0] grad_y_i = '0;
  logic signed [31:0] grad_z_i = '0;
  logic signed [31:0] strain_force_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] next_value_o, next_flux_x_o, next_flux_y_o, next_flux_z_o;
  logic signed [31:0] rate_value_o, rate_flux_x_o, rate_flux_y_o, rate_flux_z_o;
  logic        saturated_o;

  twin_phase_field_point_update_unit u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .order_value_i, .grad_x_i, .grad_y_i, .grad_z_i,
    .strain_force_i, .out_valid_o, .out_ready_i, .next_value_o, .next_flux_x_o,
    .next_flux_y_o, .next_flux_z_o, .rate_value_o, .rate_flux_x_o, .rate_flux_y_o,
    .rate_flux_z_o, .saturated_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the register file, updated whenever the testbench writes a register.
  logic [59:0]        kappa_rows [3];
  logic [59:0]        mobility_rows [3];
  logic signed [31:0] well_scale;
  logic [30:0]        step_size;

  // Results still owed by the unit, oldest first.
  point_result_t pending_results[$];
  int            fail_count = 0;

  // Set by any clip during one prediction.
  bit clip_hit;

  // Flow controls: a long receiver hold-off request and no-idle modes for receiver and sender.
  bit hold_request = 1'b0;
  bit rx_eager = 1'b0;
  bit tx_eager = 1'b0;

  // ---------------------------------------------------------------------------------------
  // Q16.16 arithmetic of the point update. Apart from the root trial square, all is held in
  // 64-bit integers; the 32-bit operands never make an exact product overflow that.
  // ---------------------------------------------------------------------------------------
  function automatic longint clip_q(longint v);
    if (v > Q16_MAX) begin
      clip_hit = 1'b1;
      return Q16_MAX;
    end
    if (v < Q16_MIN) begin
      clip_hit = 1'b1;
      return Q16_MIN;
    end
    return v;
  endfunction

  // Exact product, rounded at the shift with ties away from zero, clipped.
  function automatic longint fix_mul(longint a, longint b, int frac);
    bit                neg;
    longint unsigned   ma, mb, q, lim;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? longint'(-a) : longint'(a);
    mb  = (b < 0) ? longint'(-b) : longint'(b);
    q   = (ma * mb + (64'd1 << (frac - 1))) >> frac;
    lim = 64'd2147483647 + (neg ? 64'd1 : 64'd0);
    if (q > lim) begin
      clip_hit = 1'b1;
      q = lim;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Coefficient j of a packed tensor row, a signed Q8.12 value.
  function automatic longint tensor_coef(logic [59:0] row, int j);
    logic signed [19:0] c;
    c = row[20*j +: 20];
    return longint'(c);
  endfunction

  function automatic point_result_t update_point(logic signed [31:0] n_in,
      logic signed [31:0] gx, logic signed [31:0] gy, logic signed [31:0] gz,
      logic signed [31:0] s_in);
    longint          n, s, w, dt, a, b, p, mu, mob, t, f, filt, d, ld, lk, acc;
    longint          g [3];
    longint          kg [3];
    longint          nv [3];
    longint unsigned mg, sq_sum, root, cand, den, q;
    logic [127:0]    cand_sq;
    point_result_t   r;
    clip_hit = 1'b0;
    n = n_in;
    s = s_in;
    g[0] = gx;
    g[1] = gy;
    g[2] = gz;
    w  = well_scale;
    dt = longint'(step_size);

    // Double-well term W*4*n*(n-1)*(n-1/2).
    a  = clip_q(n - ONE);
    b  = clip_q(n - 32768);
    p  = fix_mul(n, a, 16);
    p  = fix_mul(p, b, 16);
    p  = clip_q(4 * p);
    mu = fix_mul(w, p, 16);

    // Anisotropic flux K*grad n in Q8.12 x Q16.16.
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += fix_mul(tensor_coef(kappa_rows[i], j), g[j], 12);
      kg[i] = clip_q(acc);
    end

    // Unit normal from the floor square root of the summed squares.
    sq_sum = 0;
    for (int i = 0; i < 3; i++) begin
      mg = (g[i] < 0) ? longint'(-g[i]) : longint'(g[i]);
      sq_sum += mg * mg;
    end
    root = 0;
    for (int bit_i = 48; bit_i >= 0; bit_i--) begin
      cand    = root | (64'd1 << bit_i);
      cand_sq = {64'd0, cand} * {64'd0, cand};
      if (cand_sq <= {64'd0, sq_sum}) root = cand;
    end
    den = root + 64'd1;
    for (int i = 0; i < 3; i++) begin
      mg = (g[i] < 0) ? longint'(-g[i]) : longint'(g[i]);
      q  = ((mg << 16) + den / 2) / den;
      nv[i] = (g[i] < 0) ? longint'(q) : -longint'(q);
    end

    // Directional mobility v'*M*v.
    mob = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        mob += fix_mul(tensor_coef(mobility_rows[i], j), fix_mul(nv[i], nv[j], 16), 12);
    mob = clip_q(mob);

    // Strain force filtered by 1-(2n-1)^2.
    t    = clip_q(2 * n - ONE);
    f    = clip_q(ONE - fix_mul(t, t, 16));
    filt = fix_mul(f, s, 16);
    d    = clip_q(mu - filt);
    ld   = fix_mul(mob, d, 16);

    r.next_value = 32'(clip_q(n - fix_mul(dt, ld, 16)));
    r.rate_value = 32'(clip_q(-ld));
    lk = fix_mul(mob, kg[0], 16);
    r.next_flux_x = 32'(clip_q(-fix_mul(dt, lk, 16)));
    r.rate_flux_x = 32'(clip_q(-lk));
    lk = fix_mul(mob, kg[1], 16);
    r.next_flux_y = 32'(clip_q(-fix_mul(dt, lk, 16)));
    r.rate_flux_y = 32'(clip_q(-lk));
    lk = fix_mul(mob, kg[2], 16);
    r.next_flux_z = 32'(clip_q(-fix_mul(dt, lk, 16)));
    r.rate_flux_z = 32'(clip_q(-lk));
    r.saturated = clip_hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Register writes: a setup cycle, then an access cycle. Called at a falling edge while
  // the unit is idle, returns at a falling edge.
  // ---------------------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_KAPPA0:    kappa_rows[0]    = value[59:0];
      REG_KAPPA1:    kappa_rows[1]    = value[59:0];
      REG_KAPPA2:    kappa_rows[2]    = value[59:0];
      REG_MOBILITY0: mobility_rows[0] = value[59:0];
      REG_MOBILITY1: mobility_rows[1] = value[59:0];
      REG_MOBILITY2: mobility_rows[2] = value[59:0];
      REG_WELL:      well_scale       = value[31:0];
      default:       step_size        = value[30:0];
    endcase
  endtask

  task automatic load_tensors(logic [59:0] k0, logic [59:0] k1, logic [59:0] k2,
      logic [59:0] m0, logic [59:0] m1, logic [59:0] m2, logic [31:0] w, logic [30:0] dt);
    write_reg(REG_KAPPA0, 64'(k0));
    write_reg(REG_KAPPA1, 64'(k1));
    write_reg(REG_KAPPA2, 64'(k2));
    write_reg(REG_MOBILITY0, 64'(m0));
    write_reg(REG_MOBILITY1, 64'(m1));
    write_reg(REG_MOBILITY2, 64'(m2));
    write_reg(REG_WELL, 64'(w));
    write_reg(REG_TIME_STEP, 64'(dt));
  endtask

  // ---------------------------------------------------------------------------------------
  // Sender. Each call offers one word after a random gap and returns at the falling edge
  // after acceptance, with valid still high so a zero gap keeps the stream unbroken.
  // ---------------------------------------------------------------------------------------
  task automatic send_point(point_row_t row);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    order_value_i  = row.n;
    grad_x_i       = row.gx;
    grad_y_i       = row.gy;
    grad_z_i       = row.gz;
    strain_force_i = row.s;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (row.known) pending_results.push_back(row.res);
    else pending_results.push_back(update_point(row.n, row.gx, row.gy, row.gz, row.s));
    @(negedge clk_i);
  endtask

  // Stop offering words and wait until the unit has returned everything owed.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Random tensor row: mostly modest coefficients, sometimes any bit pattern.
  function automatic logic [59:0] random_row();
    logic [59:0] r;
    if ($urandom_range(0, 3) == 0) begin
      r = 60'({$urandom(), $urandom()});
    end else begin
      for (int j = 0; j < 3; j++) r[20*j +: 20] = 20'($urandom_range(0, 16384)) - 20'd8192;
    end
    return r;
  endfunction

  // Random point: mostly values near the physical range, some raw patterns and specials.
  function automatic point_row_t random_point();
    point_row_t  r;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    r.known = 1'b0;
    r.res   = '0;
    if (mode < 2) begin
      r.n  = $urandom();
      r.gx = $urandom();
      r.gy = $urandom();
      r.gz = $urandom();
      r.s  = $urandom();
    end else begin
      r.n  = 32'($urandom_range(0, 196608)) - 32'sd65536;
      r.gx = 32'($urandom_range(0, 524288)) - 32'sd262144;
      r.gy = 32'($urandom_range(0, 524288)) - 32'sd262144;
      r.gz = 32'($urandom_range(0, 524288)) - 32'sd262144;
      r.s  = 32'($urandom_range(0, 524288)) - 32'sd262144;
    end
    if (mode == 2) begin
      r.gx = 0;
      r.gy = 0;
      r.gz = 0;
    end
    if (mode == 3) begin
      r.n  = $urandom_range(0, 1) ? VMIN : VMAX;
      r.gx = $urandom_range(0, 1) ? VMIN : VMAX;
      r.s  = $urandom_range(0, 1) ? VMIN : VMAX;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Receiver. A random wait before each word, none in no-idle mode; on request one long
  // hold-off so the pipeline fills and in_ready_o falls.
  // ---------------------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = rx_eager ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = 400;
      end
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  task automatic compare_field(string name, logic signed [31:0] expv, logic signed [31:0] actv);
    if (expv !== actv) begin
      $error("%s expected %0d actual %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  // Each word taken from the unit is matched against the oldest outstanding result.
  always @(posedge clk_i) begin
    point_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing outstanding");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("next_value", exp_res.next_value, next_value_o);
        compare_field("next_flux_x", exp_res.next_flux_x, next_flux_x_o);
        compare_field("next_flux_y", exp_res.next_flux_y, next_flux_y_o);
        compare_field("next_flux_z", exp_res.next_flux_z, next_flux_z_o);
        compare_field("rate_value", exp_res.rate_value, rate_value_o);
        compare_field("rate_flux_x", exp_res.rate_flux_x, rate_flux_x_o);
        compare_field("rate_flux_y", exp_res.rate_flux_y, rate_flux_y_o);
        compare_field("rate_flux_z", exp_res.rate_flux_z, rate_flux_z_o);
        compare_field("saturated", 32'(exp_res.saturated), 32'(saturated_o));
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("tb_twin_phase_field_point_update_unit: errors");
    $finish;
  end

  // With every register at zero the mobility is zero, so the value term is just n and every
  // flux and rate term is zero. Only the double-well and filter terms can clip, at extreme n.
  point_row_t reset_rows [4] = '{
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 1'b0}},
    '{ONE, 32'sd0, 32'sd0, 32'sd0, VMAX, 1'b1, '{ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0}},
    '{VMIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, '{VMIN, 0, 0, 0, 0, 0, 0, 0, 1'b1}},
    '{VMAX, VMAX, VMIN, VMAX, VMIN, 1'b1, '{VMAX, 0, 0, 0, 0, 0, 0, 0, 1'b1}}
  };

  // Probes under an isotropic setting: zero gradient, gradient and force extremes, each
  // axis alone, the well minima and the half point.
  point_row_t probe_rows [14] = '{
    '{32'sd32768, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 1'b0, '0},
    '{32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
    '{32'sd0, 32'sd0, -32'sd65536, 32'sd0, 32'sd0, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd131072, 32'sd0, 1'b0, '0},
    '{ONE, 32'sd1, -32'sd1, 32'sd1, 32'sd0, 1'b0, '0},
    '{32'sd16384, 32'sd40000, 32'sd30000, -32'sd20000, 32'sd50000, 1'b0, '0},
    '{32'sd32768, VMAX, VMAX, VMAX, VMAX, 1'b0, '0},
    '{32'sd32768, VMIN, VMIN, VMIN, VMIN, 1'b0, '0},
    '{VMIN, VMIN, 32'sd0, 32'sd0, VMAX, 1'b0, '0},
    '{VMAX, 32'sd0, VMAX, 32'sd0, VMIN, 1'b0, '0},
    '{-32'sd65536, 32'sd100, 32'sd200, 32'sd300, -32'sd65536, 1'b0, '0},
    '{32'sd98304, -32'sd70000, 32'sd5, 32'sd123456, 32'sd7, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, VMIN, 1'b0, '0},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------------------
  // Main sequence: reset, directed rows at the reset setting, probes under an isotropic
  // setting, then random phases, each under its own register setting.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    point_row_t row;
    for (int i = 0; i < 3; i++) begin
      kappa_rows[i]    = '0;
      mobility_rows[i] = '0;
    end
    well_scale = '0;
    step_size  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (reset_rows[i]) send_point(reset_rows[i]);
    drain_results();

    // Identity gradient tensor, mobility 0.5 on the diagonal, W = 1, dt about 0.1.
    load_tensors(60'h00000_00000_01000, 60'h00000_01000_00000, 60'h01000_00000_00000,
                 60'h00000_00000_00800, 60'h00000_00800_00000, 60'h00800_00000_00000,
                 32'h0001_0000, 31'd6554);
    foreach (probe_rows[i]) send_point(probe_rows[i]);
    drain_results();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        // Largest positive coefficients, largest W and dt.
        0: load_tensors({3{20'h7FFFF}}, {3{20'h7FFFF}}, {3{20'h7FFFF}},
                        {3{20'h7FFFF}}, {3{20'h7FFFF}}, {3{20'h7FFFF}},
                        32'h7FFF_FFFF, 31'h7FFF_FFFF);
        // Most negative coefficients and W, zero time step.
        1: load_tensors({3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}},
                        {3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}},
                        32'h8000_0000, 31'd0);
        default: load_tensors(random_row(), random_row(), random_row(), random_row(),
                              random_row(), random_row(),
                              32'($urandom_range(0, 262144)) - 32'd131072,
                              31'($urandom_range(0, 131072)));
      endcase
      // One phase streams with no idling on either side; another fills the pipeline
      // behind a long receiver hold-off while the sender keeps offering words.
      tx_eager = (phase == 3) || (phase == 5);
      rx_eager = (phase == 3);
      if (phase == 5) hold_request = 1'b1;
      for (int k = 0; k < 200; k++) begin
        row = random_point();
        send_point(row);
      end
      drain_results();
    end

    tx_eager = 1'b0;
    rx_eager = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_twin_phase_field_point_update_unit: clean");
    end else begin
      $display("tb_twin_phase_field_point_update_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/tpfpu_pkg.sv
src/tpfpu_norm.sv
src/twin_phase_field_point_update_unit.sv
verif/tb_twin_phase_field_point_update_unit.sv
